// ----- hdl/rotation_matrix_to_quaternion_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for rotation_matrix_to_quaternion
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and fixed widths for the matrix-to-quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // matrix entry and quaternion part width
    localparam int E_W = 16;
    // width of a sum or difference of two entries
    localparam int D_W = 17;
    // quotient bits kept by the dividers; more than any saturated magnitude
    localparam int QBITS = 16;

    typedef enum logic [1:0] {
        PATH_TRACE = 2'd0,
        PATH_X     = 2'd1,
        PATH_Y     = 2'd2,
        PATH_Z     = 2'd3
    } rmq_path_t;

    typedef struct packed {
        rmq_path_t path;
        logic      bad;
    } rmq_ctrl_t;

endpackage

// ----- hdl/rmq_front.sv -----
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the branch, forms the radicand and the three
// off-diagonal sums/differences, and holds them for the queue.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = 14,
    localparam int RW = (FRAC_BITS > 18 ? FRAC_BITS : 18) + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            r00,
    input  logic signed [15:0]            r01,
    input  logic signed [15:0]            r02,
    input  logic signed [15:0]            r10,
    input  logic signed [15:0]            r11,
    input  logic signed [15:0]            r12,
    input  logic signed [15:0]            r20,
    input  logic signed [15:0]            r21,
    input  logic signed [15:0]            r22,
    output logic                          fr_valid,
    input  logic                          fr_ready,
    output rmq_pkg::rmq_ctrl_t            fr_ctrl,
    output logic signed [rmq_pkg::D_W-1:0] fr_d0,
    output logic signed [rmq_pkg::D_W-1:0] fr_d1,
    output logic signed [rmq_pkg::D_W-1:0] fr_d2,
    output logic [RW-1:0]                 fr_rad
);
    import rmq_pkg::*;

    localparam int RSW = RW + 1;
    localparam logic signed [RSW-1:0] ONE_S = RSW'(1) << FRAC_BITS;

    logic signed [RSW-1:0] e00, e11, e22, tr, rad_sel;
    logic signed [D_W-1:0] d0_sel, d1_sel, d2_sel;
    logic                  trace_pos, pick_y, pick_z;
    logic signed [15:0]    dmax;
    rmq_path_t             path_sel;

    logic                  vld_reg, vld_next;
    rmq_ctrl_t             ctrl_reg;
    logic signed [D_W-1:0] d0_reg, d1_reg, d2_reg;
    logic [RW-1:0]         rad_reg;

    assign e00 = RSW'(r00);
    assign e11 = RSW'(r11);
    assign e22 = RSW'(r22);
    assign tr  = e00 + e11 + e22;

    assign trace_pos = tr > RSW'(0);
    assign pick_y    = r11 > r00;
    assign dmax      = pick_y ? r11 : r00;
    assign pick_z    = r22 > dmax;

    always_comb
    begin
        if (trace_pos)
            path_sel = PATH_TRACE;
        else if (pick_z)
            path_sel = PATH_Z;
        else if (pick_y)
            path_sel = PATH_Y;
        else
            path_sel = PATH_X;
    end

    // off-diagonal terms listed in ascending order of the quaternion slots
    // that are not the diagonal one
    always_comb
    begin
        unique case (path_sel)
            PATH_TRACE:
            begin
                rad_sel = tr + ONE_S;
                d0_sel  = D_W'(r21) - D_W'(r12);
                d1_sel  = D_W'(r02) - D_W'(r20);
                d2_sel  = D_W'(r10) - D_W'(r01);
            end
            PATH_X:
            begin
                rad_sel = e00 - (e11 + e22) + ONE_S;
                d0_sel  = D_W'(r21) - D_W'(r12);
                d1_sel  = D_W'(r10) + D_W'(r01);
                d2_sel  = D_W'(r20) + D_W'(r02);
            end
            PATH_Y:
            begin
                rad_sel = e11 - (e22 + e00) + ONE_S;
                d0_sel  = D_W'(r02) - D_W'(r20);
                d1_sel  = D_W'(r01) + D_W'(r10);
                d2_sel  = D_W'(r21) + D_W'(r12);
            end
            PATH_Z:
            begin
                rad_sel = e22 - (e00 + e11) + ONE_S;
                d0_sel  = D_W'(r10) - D_W'(r01);
                d1_sel  = D_W'(r02) + D_W'(r20);
                d2_sel  = D_W'(r12) + D_W'(r21);
            end
            default:
            begin
                rad_sel = tr + ONE_S;
                d0_sel  = '0;
                d1_sel  = '0;
                d2_sel  = '0;
            end
        endcase
    end

    assign in_ready = !vld_reg || fr_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
            vld_next = 1'b1;
        else if (fr_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ctrl_reg.path <= path_sel;
            ctrl_reg.bad  <= rad_sel <= RSW'(0);
            d0_reg        <= d0_sel;
            d1_reg        <= d1_sel;
            d2_reg        <= d2_sel;
            rad_reg       <= rad_sel[RW-1:0];
        end
    end

    assign fr_valid = vld_reg;
    assign fr_ctrl  = ctrl_reg;
    assign fr_d0    = d0_reg;
    assign fr_d1    = d1_reg;
    assign fr_d2    = d2_reg;
    assign fr_rad   = rad_reg;

endmodule

// ----- hdl/rmq_queue.sv -----
// ----------------------------------------------------------------------------
// rmq_queue
// Two-entry queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module rmq_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import rmq_pkg::*;

    logic [WIDTH-1:0] mem [0:1];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- hdl/rmq_back.sv -----
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root (one result bit per stage), three pipelined
// restoring dividers (one quotient bit per stage), then saturation and the
// output register. The whole pipeline advances unless the output stalls.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int FRAC_BITS = 14,
    localparam int RW = (FRAC_BITS > 18 ? FRAC_BITS : 18) + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           bk_valid,
    output logic                           bk_ready,
    input  rmq_pkg::rmq_ctrl_t             bk_ctrl,
    input  logic signed [rmq_pkg::D_W-1:0] bk_d0,
    input  logic signed [rmq_pkg::D_W-1:0] bk_d1,
    input  logic signed [rmq_pkg::D_W-1:0] bk_d2,
    input  logic [RW-1:0]                  bk_rad,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [15:0]             qw,
    output logic signed [15:0]             qx,
    output logic signed [15:0]             qy,
    output logic signed [15:0]             qz,
    output logic [1:0]                     path_taken,
    output logic                           bad_matrix
);
    import rmq_pkg::*;

    localparam int VW  = RW + FRAC_BITS;
    localparam int SW  = (VW + 1) / 2;
    localparam int VW2 = 2 * SW;
    localparam int NW  = FRAC_BITS + D_W + 1;
    localparam int CW  = NW > SW + QBITS + 1 ? NW : SW + QBITS + 1;
    localparam int HW  = SW > 17 ? SW : 17;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam logic [16:0] POS_LIM = 17'(ONE_I < 32767 ? ONE_I : 32767);
    localparam logic [16:0] NEG_LIM = 17'(ONE_I < 32768 ? ONE_I : 32768);

    logic adv;

    // ---------------- square root stages ----------------
    logic [VW2-1:0]  sq_v_src    [0:SW-1];
    logic [SW+1:0]   sq_rem_src  [0:SW-1];
    logic [SW-1:0]   sq_root_src [0:SW-1];
    logic [SW+3:0]   sq_cat      [0:SW-1];
    logic [SW+3:0]   sq_trial    [0:SW-1];
    logic [VW2-1:0]  sq_v_next   [0:SW-1];
    logic [SW+1:0]   sq_rem_next [0:SW-1];
    logic [SW-1:0]   sq_root_next[0:SW-1];

    logic [VW2-1:0]  sq_v_reg    [0:SW-1];
    logic [SW+1:0]   sq_rem_reg  [0:SW-1];
    logic [SW-1:0]   sq_root_reg [0:SW-1];
    logic            sq_vld_reg  [0:SW-1];
    rmq_ctrl_t       sq_ctrl_reg [0:SW-1];
    logic signed [D_W-1:0] sq_d_reg [0:SW-1][0:2];

    always_comb
    begin
        sq_v_src[0]    = VW2'(bk_rad) << FRAC_BITS;
        sq_rem_src[0]  = '0;
        sq_root_src[0] = '0;
        for (int t = 1; t < SW; t++)
        begin
            sq_v_src[t]    = sq_v_reg[t-1];
            sq_rem_src[t]  = sq_rem_reg[t-1];
            sq_root_src[t] = sq_root_reg[t-1];
        end
        for (int t = 0; t < SW; t++)
        begin
            sq_cat[t]   = {sq_rem_src[t], sq_v_src[t][VW2-1 -: 2]};
            sq_trial[t] = (SW+4)'({sq_root_src[t], 2'b01});
            sq_v_next[t] = sq_v_src[t] << 2;
            if (sq_cat[t] >= sq_trial[t])
            begin
                sq_rem_next[t]  = (SW+2)'(sq_cat[t] - sq_trial[t]);
                sq_root_next[t] = {sq_root_src[t][SW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[t]  = sq_cat[t][SW+1:0];
                sq_root_next[t] = {sq_root_src[t][SW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t < SW; t++)
            begin
                sq_v_reg[t]    <= sq_v_next[t];
                sq_rem_reg[t]  <= sq_rem_next[t];
                sq_root_reg[t] <= sq_root_next[t];
            end
            sq_ctrl_reg[0] <= bk_ctrl;
            sq_d_reg[0][0] <= bk_d0;
            sq_d_reg[0][1] <= bk_d1;
            sq_d_reg[0][2] <= bk_d2;
            for (int t = 1; t < SW; t++)
            begin
                sq_ctrl_reg[t] <= sq_ctrl_reg[t-1];
                for (int l = 0; l < 3; l++)
                    sq_d_reg[t][l] <= sq_d_reg[t-1][l];
            end
        end
    end

    // ---------------- divider stages ----------------
    // stage 0 sets up numerator and overflow, stages 1..QBITS take one bit
    logic [SW-1:0]   s_root;
    logic [SW:0]     s_den;
    logic [SW:0]     s_inc;
    logic [D_W-1:0]  dv_mag      [0:2];
    logic [CW-1:0]   dv_num      [0:2];

    logic [CW-1:0]   dv_rem_next [0:QBITS][0:2];
    logic [QBITS-1:0] dv_q_next  [0:QBITS][0:2];
    logic            dv_ovf_next [0:QBITS][0:2];
    logic [CW-1:0]   dv_dk       [1:QBITS];

    logic [CW-1:0]   dv_rem_reg  [0:QBITS][0:2];
    logic [QBITS-1:0] dv_q_reg   [0:QBITS][0:2];
    logic            dv_ovf_reg  [0:QBITS][0:2];
    logic            dv_neg_reg  [0:QBITS][0:2];
    logic [SW:0]     dv_den_reg  [0:QBITS];
    logic [SW-1:0]   dv_half_reg [0:QBITS];
    rmq_ctrl_t       dv_ctrl_reg [0:QBITS];
    logic            dv_vld_reg  [0:QBITS];

    assign s_root = sq_root_reg[SW-1];
    assign s_den  = {s_root, 1'b0};
    assign s_inc  = {1'b0, s_root} + (SW+1)'(1);

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            dv_mag[l] = sq_d_reg[SW-1][l][D_W-1] ? D_W'(~sq_d_reg[SW-1][l] + 1'b1)
                                                 : D_W'(sq_d_reg[SW-1][l]);
            dv_num[l] = (CW'(dv_mag[l]) << FRAC_BITS) + CW'(s_root);
            dv_rem_next[0][l] = dv_num[l];
            dv_q_next[0][l]   = '0;
            dv_ovf_next[0][l] = dv_num[l] >= (CW'(s_den) << QBITS);
        end
        for (int t = 1; t <= QBITS; t++)
        begin
            dv_dk[t] = CW'(dv_den_reg[t-1]) << (QBITS - t);
            for (int l = 0; l < 3; l++)
            begin
                dv_ovf_next[t][l] = dv_ovf_reg[t-1][l];
                dv_q_next[t][l]   = dv_q_reg[t-1][l];
                if (dv_rem_reg[t-1][l] >= dv_dk[t])
                begin
                    dv_rem_next[t][l] = dv_rem_reg[t-1][l] - dv_dk[t];
                    dv_q_next[t][l][QBITS-t] = 1'b1;
                end
                else
                begin
                    dv_rem_next[t][l] = dv_rem_reg[t-1][l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t <= QBITS; t++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    dv_rem_reg[t][l] <= dv_rem_next[t][l];
                    dv_q_reg[t][l]   <= dv_q_next[t][l];
                    dv_ovf_reg[t][l] <= dv_ovf_next[t][l];
                end
            end
            for (int l = 0; l < 3; l++)
                dv_neg_reg[0][l] <= sq_d_reg[SW-1][l][D_W-1];
            dv_den_reg[0]  <= s_den;
            dv_half_reg[0] <= s_inc[SW:1];
            dv_ctrl_reg[0] <= sq_ctrl_reg[SW-1];
            for (int t = 1; t <= QBITS; t++)
            begin
                for (int l = 0; l < 3; l++)
                    dv_neg_reg[t][l] <= dv_neg_reg[t-1][l];
                dv_den_reg[t]  <= dv_den_reg[t-1];
                dv_half_reg[t] <= dv_half_reg[t-1];
                dv_ctrl_reg[t] <= dv_ctrl_reg[t-1];
            end
        end
    end

    // ---------------- valid chain ----------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < SW; t++)
                sq_vld_reg[t] <= 1'b0;
            for (int t = 0; t <= QBITS; t++)
                dv_vld_reg[t] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= bk_valid;
            for (int t = 1; t < SW; t++)
                sq_vld_reg[t] <= sq_vld_reg[t-1];
            dv_vld_reg[0] <= sq_vld_reg[SW-1];
            for (int t = 1; t <= QBITS; t++)
                dv_vld_reg[t] <= dv_vld_reg[t-1];
            out_valid_reg <= dv_vld_reg[QBITS];
        end
    end

    assign adv      = !(out_valid_reg && !out_ready);
    assign bk_ready = adv;

    // ---------------- saturation and slot assembly ----------------
    function automatic logic [15:0] sat_part(input logic neg, input logic ovf,
                                             input logic [QBITS-1:0] q);
        logic [16:0] mag;
        logic [16:0] lim;
        logic [16:0] m;
        begin
            mag = ovf ? 17'h1FFFF : 17'(q);
            lim = neg ? NEG_LIM : POS_LIM;
            m   = (mag > lim) ? lim : mag;
            return neg ? 16'(~m + 17'd1) : 16'(m);
        end
    endfunction

    logic [15:0] lane_val [0:2];
    logic [15:0] half_val;
    logic [15:0] slot_val [0:3];
    logic [HW-1:0] half_ext;
    rmq_ctrl_t   fin_ctrl;

    assign fin_ctrl = dv_ctrl_reg[QBITS];
    assign half_ext = HW'(dv_half_reg[QBITS]);
    assign half_val = (half_ext > HW'(POS_LIM)) ? 16'(POS_LIM) : 16'(half_ext);

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            lane_val[l] = sat_part(dv_neg_reg[QBITS][l], dv_ovf_reg[QBITS][l],
                                   dv_q_reg[QBITS][l]);
        slot_val[0] = (fin_ctrl.path == PATH_TRACE) ? half_val : lane_val[0];
        if (fin_ctrl.path == PATH_X)
            slot_val[1] = half_val;
        else if (fin_ctrl.path == PATH_TRACE)
            slot_val[1] = lane_val[0];
        else
            slot_val[1] = lane_val[1];
        if (fin_ctrl.path == PATH_Y)
            slot_val[2] = half_val;
        else if (fin_ctrl.path == PATH_Z)
            slot_val[2] = lane_val[2];
        else
            slot_val[2] = lane_val[1];
        slot_val[3] = (fin_ctrl.path == PATH_Z) ? half_val : lane_val[2];
        if (fin_ctrl.bad)
        begin
            for (int n = 0; n < 4; n++)
                slot_val[n] = '0;
        end
    end

    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic [1:0]         path_reg;
    logic               bad_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qw_reg   <= slot_val[0];
            qx_reg   <= slot_val[1];
            qy_reg   <= slot_val[2];
            qz_reg   <= slot_val[3];
            path_reg <= fin_ctrl.path;
            bad_reg  <= fin_ctrl.bad;
        end
    end

    assign out_valid  = out_valid_reg;
    assign qw         = qw_reg;
    assign qx         = qx_reg;
    assign qy         = qy_reg;
    assign qz         = qz_reg;
    assign path_taken = path_reg;
    assign bad_matrix = bad_reg;

endmodule

// ----- hdl/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q1.FRAC_BITS 3x3 rotation matrix to a quaternion.
// Input channel: in_valid/in_ready, nine entries r00..r22 per transfer.
// Output channel: out_valid/out_ready, qw qx qy qz saturated to +-1.0, the
// branch taken (trace, or largest diagonal x/y/z) and a bad-radicand flag
// that forces all four parts to zero.
// Throughput: one matrix per cycle while the receiver keeps out_ready high.
// The square root takes SW stages, where SW = ceil((2*FRAC_BITS + 1) / 2) for
// FRAC_BITS >= 18 and ceil((FRAC_BITS + 19) / 2) below; the dividers take
// QBITS + 1 stages.
// A two-entry queue separates the classify stage from the arithmetic
// pipeline. When the receiver holds out_ready low, the arithmetic pipeline
// freezes, the queue fills, then in_ready drops; nothing is lost.
// Reset (rst_n low, async) empties every stage; in_ready is already high in reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] r00,
    input  logic signed [15:0] r01,
    input  logic signed [15:0] r02,
    input  logic signed [15:0] r10,
    input  logic signed [15:0] r11,
    input  logic signed [15:0] r12,
    input  logic signed [15:0] r20,
    input  logic signed [15:0] r21,
    input  logic signed [15:0] r22,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] qw,
    output logic signed [15:0] qx,
    output logic signed [15:0] qy,
    output logic signed [15:0] qz,
    output logic [1:0]         path_taken,
    output logic               bad_matrix
);
    import rmq_pkg::*;

`include "rotation_matrix_to_quaternion_assert.svh"

    localparam int RW = (FRAC_BITS > 18 ? FRAC_BITS : 18) + 1;
    localparam int QW = $bits(rmq_ctrl_t) + 3 * D_W + RW;

    // front stage -> queue
    logic                  fr_valid, fr_ready;
    rmq_ctrl_t             fr_ctrl;
    logic signed [D_W-1:0] fr_d0, fr_d1, fr_d2;
    logic [RW-1:0]         fr_rad;

    // queue -> arithmetic pipeline
    logic                  bk_valid, bk_ready;
    logic [QW-1:0]         q_wr_data, q_rd_data;
    rmq_ctrl_t             bk_ctrl;
    logic signed [D_W-1:0] bk_d0, bk_d1, bk_d2;
    logic [RW-1:0]         bk_rad;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .r00      (r00),
        .r01      (r01),
        .r02      (r02),
        .r10      (r10),
        .r11      (r11),
        .r12      (r12),
        .r20      (r20),
        .r21      (r21),
        .r22      (r22),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready),
        .fr_ctrl  (fr_ctrl),
        .fr_d0    (fr_d0),
        .fr_d1    (fr_d1),
        .fr_d2    (fr_d2),
        .fr_rad   (fr_rad)
    );

    assign q_wr_data = {fr_ctrl, fr_d0, fr_d1, fr_d2, fr_rad};

    rmq_queue #(.WIDTH(QW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_data  (q_rd_data)
    );

    assign {bk_ctrl, bk_d0, bk_d1, bk_d2, bk_rad} = q_rd_data;

    rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bk_valid   (bk_valid),
        .bk_ready   (bk_ready),
        .bk_ctrl    (bk_ctrl),
        .bk_d0      (bk_d0),
        .bk_d1      (bk_d1),
        .bk_d2      (bk_d2),
        .bk_rad     (bk_rad),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .qw         (qw),
        .qx         (qx),
        .qy         (qy),
        .qz         (qz),
        .path_taken (path_taken),
        .bad_matrix (bad_matrix)
    );

    // a bad radicand can only come from a diagonal branch and zeroes all parts
    `RMQ_ASSERT_IMPL(a_bad_zero, out_valid && bad_matrix,
        qw == 16'sd0 && qx == 16'sd0 && qy == 16'sd0 && qz == 16'sd0,
        "bad matrix with nonzero quaternion")
    `RMQ_ASSERT_IMPL(a_trace_good, out_valid && path_taken == PATH_TRACE, !bad_matrix,
        "trace branch flagged bad")
    // a stalled output freezes the arithmetic pipeline
    `RMQ_ASSERT_IMPL(a_stall_freeze, out_valid && !out_ready, !bk_ready,
        "pipeline advanced under output stall")
    // an accepted matrix is held by the front stage next cycle
    `RMQ_ASSERT_NEXT(a_front_load, in_valid && in_ready, fr_valid,
        "accepted matrix not held by front stage")

endmodule

// ----- test/rotation_matrix_to_quaternion_check.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_check
// Watches both channels, predicts each quaternion from the accepted matrix
// and compares it field by field with the next output transfer.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_check #(
    parameter int FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] qw, qx, qy, qz,
    input  logic [1:0]         path_taken,
    input  logic               bad_matrix,
    output int                 fail_count,
    output int                 pending,
    output int                 quat_count,
    output int                 bad_count,
    output int                 path_hits [4]
);
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        rmq_path_t          path;
        logic               bad;
    } quat_t;

    quat_t quat_fifo [$];

    function automatic longint int_sqrt(longint v);
        longint res, b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // d / 2s rounded to nearest, ties away from zero
    function automatic longint scaled_div(longint d, longint s);
        longint mag, q;
        mag = (d < 0) ? -d : d;
        q = ((mag << FRAC_BITS) + s) / (2 * s);
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] sat(longint v);
        longint one;
        one = longint'(1) << FRAC_BITS;
        if (v > one) v = one;
        if (v < -one) v = -one;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic quat_t convert(longint m [3][3]);
        longint q [4];
        longint one, tr, rad, s;
        int i, j, k;
        quat_t res;
        q = '{0, 0, 0, 0};
        one = longint'(1) << FRAC_BITS;
        res.bad = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            res.path = PATH_TRACE;
            s = int_sqrt((tr + one) << FRAC_BITS);
            q[0] = (s + 1) >> 1;
            q[1] = scaled_div(m[2][1] - m[1][2], s);
            q[2] = scaled_div(m[0][2] - m[2][0], s);
            q[3] = scaled_div(m[1][0] - m[0][1], s);
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            res.path = rmq_path_t'(i + 1);
            rad = m[i][i] - (m[j][j] + m[k][k]) + one;
            if (rad <= 0)
                res.bad = 1'b1;
            else
            begin
                s = int_sqrt(rad << FRAC_BITS);
                q[i + 1] = (s + 1) >> 1;
                q[0] = scaled_div(m[k][j] - m[j][k], s);
                q[j + 1] = scaled_div(m[j][i] + m[i][j], s);
                q[k + 1] = scaled_div(m[k][i] + m[i][k], s);
            end
        end
        res.w = sat(q[0]);
        res.x = sat(q[1]);
        res.y = sat(q[2]);
        res.z = sat(q[3]);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint m [3][3];
        quat_t exp_q;
        if (!rst_n)
        begin
            fail_count <= 0;
            quat_count <= 0;
            bad_count <= 0;
            pending <= 0;
            path_hits <= '{0, 0, 0, 0};
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (quat_fifo.size() == 0)
                begin
                    $error("unexpected output transfer");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_q = quat_fifo.pop_front();
                    quat_count <= quat_count + 1;
                    if (exp_q.bad) bad_count <= bad_count + 1;
                    path_hits[exp_q.path] <= path_hits[exp_q.path] + 1;
                    if (qw !== exp_q.w || qx !== exp_q.x || qy !== exp_q.y
                        || qz !== exp_q.z || path_taken !== exp_q.path
                        || bad_matrix !== exp_q.bad)
                        fail_count <= fail_count + 1;
                    if (qw !== exp_q.w)
                        $error("qw expected %0d got %0d", exp_q.w, qw);
                    if (qx !== exp_q.x)
                        $error("qx expected %0d got %0d", exp_q.x, qx);
                    if (qy !== exp_q.y)
                        $error("qy expected %0d got %0d", exp_q.y, qy);
                    if (qz !== exp_q.z)
                        $error("qz expected %0d got %0d", exp_q.z, qz);
                    if (path_taken !== exp_q.path)
                        $error("path_taken expected %0d got %0d", exp_q.path,
                               path_taken);
                    if (bad_matrix !== exp_q.bad)
                        $error("bad_matrix expected %0d got %0d", exp_q.bad,
                               bad_matrix);
                end
            end
            if (in_valid && in_ready)
            begin
                m[0][0] = r00; m[0][1] = r01; m[0][2] = r02;
                m[1][0] = r10; m[1][1] = r11; m[1][2] = r12;
                m[2][0] = r20; m[2][1] = r21; m[2][2] = r22;
                quat_fifo.push_back(convert(m));
            end
            pending <= quat_fifo.size();
        end
    end
endmodule

// ----- test/rotation_matrix_to_quaternion_test.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Drives matrices into the converter with bursty input and a stalling
// receiver; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 14;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int RANDOM_MATS = 1730;
    // generous: every item with the longest gap and stall, many times over
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] r00 = '0, r01 = '0, r02 = '0, r10 = '0, r11 = '0;
    logic signed [15:0] r12 = '0, r20 = '0, r21 = '0, r22 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] qw, qx, qy, qz;
    logic [1:0] path_taken;
    logic bad_matrix;

    int fail_count, pending, quat_count, bad_count;
    int path_hits [4];
    int cycle_count = 0;
    bit hold_off = 1'b0;     // long receiver stall requested by the stimulus
    bit stimulus_done = 1'b0;

    always #5 clk = ~clk;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC_BITS)) dut (.*);

    rotation_matrix_to_quaternion_check #(.FRAC_BITS(FRAC_BITS)) checker_i (.*);

    // Watchdog: any hang ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: alternates open stretches, random stalls and heavy stalls,
    // and holds out_ready low entirely while hold_off is set.
    always @(posedge clk)
    begin
        int mode;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
        begin
            mode = (cycle_count / 200) % 4;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Long hold-off, counted in cycles here, while the sender keeps offering.
    initial
    begin
        wait (stimulus_done == 1'b0 && cycle_count > 600);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // One matrix transfer; valid stays high until in_ready is seen.
    task automatic send_matrix(input logic signed [15:0] m [9]);
        r00 <= m[0]; r01 <= m[1]; r02 <= m[2];
        r10 <= m[3]; r11 <= m[4]; r12 <= m[5];
        r20 <= m[6]; r21 <= m[7]; r22 <= m[8];
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] rnd_entry();
        return 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endfunction

    // Signed permutation matrix, random in order and signs, perturbed
    // slightly, so the diagonal branches are all reached with valid data.
    function automatic void perm_matrix(ref logic signed [15:0] m [9]);
        int p [3];
        int t;
        p = '{0, 1, 2};
        for (int a = 2; a > 0; a--)
        begin
            t = $urandom_range(0, a);
            {p[a], p[t]} = {p[t], p[a]};
        end
        for (int i = 0; i < 9; i++)
            m[i] = 16'($signed($urandom_range(0, 400)) - 200);
        for (int r = 0; r < 3; r++)
            m[r * 3 + p[r]] = $urandom_range(0, 1) ? 16'(ONE - $urandom_range(0, 300))
                                                  : 16'(-ONE + $urandom_range(0, 300));
    endfunction

    initial
    begin
        logic signed [15:0] m [9];
        int burst;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, half turns about each axis, a quarter turn, extremes
        // of the entries, saturation and raw bit extremes.
        m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};          send_matrix(m);
        m = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};        send_matrix(m);
        m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};        send_matrix(m);
        m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};        send_matrix(m);
        m = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};         send_matrix(m);
        m = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}; send_matrix(m);
        m = '{-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE};
        send_matrix(m);
        m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};       send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                send_matrix(m);
        m = '{1, -ONE, ONE, ONE, 0, -ONE, -ONE, ONE, 0}; send_matrix(m);
        m = '{-ONE + 1, ONE, -ONE, -ONE, -ONE, ONE, ONE, -ONE, -ONE};
        send_matrix(m);
        m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_matrix(m);
        m = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_matrix(m);
        m = '{16'shffff, 16'sh5555, 16'shaaaa, 16'sh8000, 16'sh7fff,
              16'sh0001, 16'sh2aaa, 16'sh4000, 16'shc000};
        send_matrix(m);
        m = '{0, 0, 0, 0, 1, 0, 0, 0, -1};               send_matrix(m);
        m = '{-ONE, 16'sh7fff, 16'sh8000, 16'sh8000, 1, 16'sh7fff,
              16'sh7fff, 16'sh8000, 0};
        send_matrix(m);

        // Random: mostly near-rotations, some arbitrary entries, some full
        // 16-bit noise, in bursts with random gaps.
        burst = 0;
        for (int n = 0; n < RANDOM_MATS; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    for (int i = 0; i < 9; i++) m[i] = rnd_entry();
                2:
                    for (int i = 0; i < 9; i++) m[i] = 16'($urandom());
                default:
                    perm_matrix(m);
            endcase
            send_matrix(m);
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0)
                    idle_gap($urandom_range(1, 12));
            end
            else
                burst--;
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;

        // let the checker's count take in the last transfer before polling
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d matrices: %0d trace, %0d/%0d/%0d diagonal x/y/z",
                 quat_count, path_hits[0], path_hits[1], path_hits[2], path_hits[3]);
        $display("%0d flagged with a bad radicand, %0d mismatching transfers",
                 bad_count, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
